[src/hamming_coded_ook_frame_sender_defines.svh]
// Assertion macros for the OOK frame sender RTL.
// Used by modules that check their own logic; no other dependencies.
`ifndef HAMMING_CODED_OOK_FRAME_SENDER_DEFINES_SVH
`define HAMMING_CODED_OOK_FRAME_SENDER_DEFINES_SVH
`ifndef SYNTH
`define HOCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HOCS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HOCS_ASSERT(lbl, prop, msg)
`define HOCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/hocs_pkg.sv]
// Shared types, constants and the extended Hamming (16,8) coder function
// for the OOK frame sender. No dependencies.
package hocs_pkg;

   localparam int MaxWords     = 32;
   localparam int PreambleBits = 11;
   localparam int PatternW     = 11;
   localparam int WordW        = 16;

   localparam logic [PatternW-1:0] PatternReset = 11'b11100010010;

   localparam int WcntW   = $clog2(MaxWords + 1);
   localparam int IdxW    = (MaxWords > 1) ? $clog2(MaxWords) : 1;
   localparam int BitPosW = $clog2(MaxWords * WordW + 1);
   localparam int PrePosW = $clog2(PreambleBits + 1);
   localparam int CmpW    = WcntW + 4;

   localparam logic FuncLoad = 1'b0;
   localparam logic FuncTick = 1'b1;

   typedef enum logic [1:0] {
      PH_PREAMBLE = 2'd0,
      PH_PAYLOAD  = 2'd1,
      PH_DONE     = 2'd2
   } phase_type;

   typedef struct packed {
      logic        carrier_on;
      logic [1:0]  phase;
      logic [15:0] coded_word;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic fire;
      logic func;
   } step_type;

   localparam logic [3:0] DataPos [8] = '{4'd12, 4'd11, 4'd10, 4'd9,
                                          4'd7, 4'd6, 4'd5, 4'd3};

   // code position j lands on word bit 15-j
   function automatic logic [15:0] code_byte(input logic [7:0] b);
      logic [15:0] c;
      logic [15:0] w;
      logic        p;
      c = '0;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         c[DataPos[i]] = b[i];
      end
      c[13] = 1'b0;
      c[14] = 1'b1;
      c[15] = 1'b0;
      for (int k = 0; k < 4; k++) begin
         p = 1'b0;
         for (int j = 3; j < 16; j++) begin
            if (((j & (1 << k)) != 0) && (j != (1 << k))) begin
               p = p ^ c[j];
            end
         end
         c[1 << k] = p;
      end
      c[0] = ^c[15:1];
      for (int j = 0; j < 16; j++) begin
         w[15-j] = c[j];
      end
      return w;
   endfunction

endpackage

[src/hocs_channels.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing.
interface hocs_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface hocs_rsp_if;
   logic        valid;
   logic        ready;
   logic        carrier_on;
   logic [1:0]  phase;
   logic [15:0] coded_word;
   logic        status;
   modport source (output valid, output carrier_on, output phase,
                   output coded_word, output status, input ready);
   modport sink   (input valid, input carrier_on, input phase,
                   input coded_word, input status, output ready);
endinterface

[src/hocs_encoder.sv]
// Extended Hamming (16,8) encoder, pure combinational.
// Depends on hocs_pkg.
module hocs_encoder
   import hocs_pkg::*;
(
   input  logic [7:0]  data_byte,
   output logic [15:0] coded_word
);

   assign coded_word = code_byte(data_byte);

endmodule

[src/hocs_tx_core.sv]
// Word store, preamble/payload bit counters and result formation.
// Depends on hocs_pkg and hamming_coded_ook_frame_sender_defines.svh.
`include "hamming_coded_ook_frame_sender_defines.svh"
module hocs_tx_core
   import hocs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [PatternW-1:0] csr_wr_data,
   input  step_type            step,
   input  logic [15:0]         coded_word,
   output rsp_type             result
);

   logic [PatternW-1:0] pattern_ff;
   logic [WcntW-1:0]    wcnt_ff, wcnt_in;
   logic [PrePosW-1:0]  pre_pos_ff, pre_pos_in;
   logic [BitPosW-1:0]  pay_pos_ff, pay_pos_in;
   logic [15:0]         store_ff [MaxWords];

   logic                full;
   logic                pre_busy;
   logic                pay_busy;
   logic                pay_busy_new;
   logic [WcntW-1:0]    wcnt_new;
   logic [3:0]          sh;
   logic [15:0]         pattern_ext;
   logic [15:0]         rd_word;
   logic                do_store;

   localparam logic [3:0] PreLast = 4'(PreambleBits - 1);

   assign full         = (wcnt_ff == WcntW'(MaxWords));
   assign wcnt_new     = full ? wcnt_ff : wcnt_ff + 1'b1;
   assign pre_busy     = (pre_pos_ff < PrePosW'(PreambleBits));
   assign pay_busy     = (CmpW'(pay_pos_ff) < {wcnt_ff, 4'b0000});
   assign pay_busy_new = (CmpW'(pay_pos_ff) < {wcnt_new, 4'b0000});
   assign sh           = PreLast - 4'(pre_pos_ff);
   assign pattern_ext  = 16'(pattern_ff);
   assign rd_word      = store_ff[pay_pos_ff[IdxW+3:4]];
   assign do_store     = step.fire && (step.func == FuncLoad) && !full;

   always_comb begin
      result     = '0;
      wcnt_in    = wcnt_ff;
      pre_pos_in = pre_pos_ff;
      pay_pos_in = pay_pos_ff;
      if (step.func == FuncLoad) begin
         result.coded_word = coded_word;
         result.status     = full;
         wcnt_in           = wcnt_new;
         if (pre_busy) begin
            result.phase = PH_PREAMBLE;
         end else if (pay_busy_new) begin
            result.phase = PH_PAYLOAD;
         end else begin
            result.phase = PH_DONE;
         end
      end else if (pre_busy) begin
         result.carrier_on = pattern_ext[sh];
         result.phase      = PH_PREAMBLE;
         pre_pos_in        = pre_pos_ff + 1'b1;
      end else if (pay_busy) begin
         result.carrier_on = rd_word[pay_pos_ff[3:0]];
         result.phase      = PH_PAYLOAD;
         pay_pos_in        = pay_pos_ff + 1'b1;
      end else begin
         result.phase = PH_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PatternReset;
         wcnt_ff    <= '0;
         pre_pos_ff <= '0;
         pay_pos_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            pattern_ff <= csr_wr_data;
         end
         if (step.fire) begin
            wcnt_ff    <= wcnt_in;
            pre_pos_ff <= pre_pos_in;
            pay_pos_ff <= pay_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         store_ff[wcnt_ff[IdxW-1:0]] <= coded_word;
      end
   end

   `HOCS_ASSERT(a_wcnt_bound, wcnt_ff <= WcntW'(MaxWords), "word count past store depth")
   `HOCS_ASSERT(a_pre_bound, pre_pos_ff <= PrePosW'(PreambleBits), "preamble index overrun")
   `HOCS_ASSERT(a_pay_bound, CmpW'(pay_pos_ff) <= {wcnt_ff, 4'b0000}, "sent past stored bits")
   `HOCS_ASSERT(a_pay_hold, (step.fire && step.func == FuncTick && pre_busy) |=> pay_pos_ff == $past(pay_pos_ff), "payload moved in preamble")
   `HOCS_ASSERT(a_full_drop, (step.fire && step.func == FuncLoad && full) |=> wcnt_ff == $past(wcnt_ff), "dropped load changed count")

endmodule

[src/hamming_coded_ook_frame_sender.sv]
// Top level of the Hamming-coded OOK frame sender: input register, coder,
// sender core and response register. Depends on hocs_pkg, hocs_channels,
// hocs_encoder and hocs_tx_core.
//
//   channel   dir  handshake          payload
//   req_bus   in   valid/ready        func, data_byte
//   rsp_bus   out  valid/ready        carrier_on, phase, coded_word, status
//   csr_*     in   csr_wr_en strobe   csr_wr_data (preamble pattern)
//
// One beat per cycle sustained while rsp_bus.ready stays high; a taken request
// moves through the input register, then the response register.
// The input register takes a request while a finished response waits on
// rsp_bus.ready only if it is empty; otherwise it holds its beat.
// Synchronous active-high reset clears counters and valids and restores the
// default preamble pattern; the word store is not cleared.
module hamming_coded_ook_frame_sender
   import hocs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [PatternW-1:0] csr_wr_data,
   hocs_req_if.sink            req_bus,
   hocs_rsp_if.source          rsp_bus
);

   logic        s0_valid_ff, s0_valid_in;
   logic        s0_func_ff;
   logic [7:0]  s0_byte_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;
   rsp_type     result;
   logic [15:0] coded;
   logic        adv;
   logic        take;
   step_type    step;

   assign adv           = s0_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s0_valid_ff || adv;
   assign take          = req_bus.valid && req_bus.ready;
   assign s0_valid_in   = take || (s0_valid_ff && !adv);
   assign out_valid_in  = adv || (out_valid_ff && !rsp_bus.ready);
   assign step.fire     = adv;
   assign step.func     = s0_func_ff;

   hocs_encoder u_encoder (
      .data_byte  (s0_byte_ff),
      .coded_word (coded)
   );

   hocs_tx_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .coded_word  (coded),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s0_func_ff <= req_bus.func;
         s0_byte_ff <= req_bus.data_byte;
      end
      if (adv) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.carrier_on = out_ff.carrier_on;
   assign rsp_bus.phase      = out_ff.phase;
   assign rsp_bus.coded_word = out_ff.coded_word;
   assign rsp_bus.status     = out_ff.status;

endmodule

[test/tb_hamming_coded_ook_frame_sender.sv]
// Testbench for hamming_coded_ook_frame_sender: random and directed beats with
// a built-in frame predictor checked against every response beat.
// Depends on hocs_pkg, hocs_channels and the sender RTL.
`timescale 1ns / 100ps

module tb_hamming_coded_ook_frame_sender;
   import hocs_pkg::*;

   localparam int HoldLen    = 60;
   localparam int CycleLimit = 200000;
   localparam int SegItems   = 200;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [PatternW-1:0] csr_wr_data = '0;

   hocs_req_if req_bus ();
   hocs_rsp_if rsp_bus ();

   hamming_coded_ook_frame_sender dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   beat_type tx_items [$];
   rsp_type  due_results [$];

   // frame state mirror
   logic [WordW-1:0]    frame_words [MaxWords];
   int unsigned         words_held = 0;
   int unsigned         preamble_idx = 0;
   int unsigned         payload_idx = 0;
   logic [PatternW-1:0] preamble_reg = PatternReset;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned loads_sent = 0;
   int unsigned hold_left = 0;
   logic        hold_start = 1'b0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [WordW-1:0] hamming_word(input logic [7:0] b);
      logic [15:0] pos;
      logic [15:0] w;
      pos = 16'h4000;
      pos[12] = b[0];
      pos[11] = b[1];
      pos[10] = b[2];
      pos[9]  = b[3];
      pos[7]  = b[4];
      pos[6]  = b[5];
      pos[5]  = b[6];
      pos[3]  = b[7];
      pos[1]  = ^(pos & 16'hAAAA);
      pos[2]  = ^(pos & 16'hCCCC);
      pos[4]  = ^(pos & 16'hF0F0);
      pos[8]  = ^(pos & 16'hFF00);
      pos[0]  = ^pos[15:1];
      for (int j = 0; j < 16; j++) begin
         w[15-j] = pos[j];
      end
      return w;
   endfunction

   function automatic phase_type frame_phase();
      if (preamble_idx < PreambleBits) return PH_PREAMBLE;
      if (payload_idx < words_held * WordW) return PH_PAYLOAD;
      return PH_DONE;
   endfunction

   function automatic rsp_type frame_sender_step(input logic func, input logic [7:0] b);
      rsp_type r;
      r = '0;
      if (func == FuncLoad) begin
         r.coded_word = hamming_word(b);
         if (words_held < MaxWords) begin
            frame_words[words_held] = r.coded_word;
            words_held++;
         end else begin
            r.status = 1'b1;
         end
         r.phase = frame_phase();
      end else if (preamble_idx < PreambleBits) begin
         r.carrier_on = preamble_reg[PreambleBits-1-preamble_idx];
         r.phase = PH_PREAMBLE;
         preamble_idx++;
      end else if (payload_idx < words_held * WordW) begin
         r.carrier_on = frame_words[payload_idx / WordW][payload_idx % WordW];
         r.phase = PH_PAYLOAD;
         payload_idx++;
      end else begin
         r.phase = PH_DONE;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin : drive
      beat_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.func <= FuncTick;
         req_bus.data_byte <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            due_results.push_back(frame_sender_step(req_bus.func, req_bus.data_byte));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = tx_items.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.func <= nxt.func;
               req_bus.data_byte <= nxt.data_byte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic flag_error(input string what, input rsp_type want, input rsp_type got);
      errors++;
      if (errors <= 10) begin
         $display("%0t %s: want carrier %0b phase %0d word %h status %0b, got carrier %0b phase %0d word %h status %0b",
                  $time, what, want.carrier_on, want.phase, want.coded_word, want.status,
                  got.carrier_on, got.phase, got.coded_word, got.status);
      end
   endtask

   // monitor
   always @(posedge clock) begin : check
      rsp_type want;
      rsp_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.carrier_on = rsp_bus.carrier_on;
            got.phase = rsp_bus.phase;
            got.coded_word = rsp_bus.coded_word;
            got.status = rsp_bus.status;
            if (due_results.size() == 0) begin
               flag_error("unexpected beat", '0, got);
            end else begin
               want = due_results.pop_front();
               if (got.carrier_on !== want.carrier_on || got.phase !== want.phase ||
                   got.coded_word !== want.coded_word || got.status !== want.status) begin
                  flag_error("mismatch", want, got);
               end
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HoldLen;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_beat(input logic func, input logic [7:0] b);
      beat_type t;
      t.func = func;
      t.data_byte = b;
      tx_items.push_back(t);
      if (func == FuncLoad) loads_sent++;
   endtask

   task automatic queue_ticks(input int n);
      for (int i = 0; i < n; i++) begin
         queue_beat(FuncTick, 8'($urandom_range(255)));
      end
   endtask

   task automatic settle();
      do @(negedge clock);
      while (tx_items.size() != 0 || req_bus.valid || due_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_pattern(input logic [PatternW-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      preamble_reg = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // loads before any tick, then preamble split across three patterns
      queue_beat(FuncLoad, 8'h00);
      queue_beat(FuncLoad, 8'hFF);
      queue_ticks(3);
      settle();
      write_pattern('1);
      queue_ticks(4);
      queue_beat(FuncLoad, 8'h5A);
      settle();
      write_pattern('0);
      queue_ticks(12);
      settle();
      write_pattern(PatternW'($urandom_range(2047)));

      for (int seg = 0; seg < 4; seg++) begin
         case (seg)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 88;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 88;
            end
            default: begin
               send_idle_pct = 34;
               recv_stall_pct = 34;
            end
         endcase
         for (int i = 0; i < SegItems; i++) begin
            queue_beat(($urandom_range(15) == 0) ? FuncLoad : FuncTick,
                       8'($urandom_range(255)));
         end
         if (seg == 0) begin
            @(negedge clock);
            hold_start = 1'b1;
            @(negedge clock);
            hold_start = 1'b0;
         end
         settle();
         write_pattern(PatternW'($urandom_range(2047)));
      end

      // make sure the store overflows
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (loads_sent < MaxWords + 3) begin
         queue_beat(FuncLoad, 8'($urandom_range(255)));
      end
      queue_ticks(20);
      settle();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[hamming_coded_ook_frame_sender.f]
+incdir+src
src/hocs_pkg.sv
src/hocs_channels.sv
src/hocs_encoder.sv
src/hocs_tx_core.sv
src/hamming_coded_ook_frame_sender.sv
test/tb_hamming_coded_ook_frame_sender.sv
